@@ hw/rtl/proximity_beep_tone_controller_assert.svh @@
// Assertion macros for the proximity beep tone controller.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef PROXIMITY_BEEP_TONE_CONTROLLER_ASSERT_SVH
`define PROXIMITY_BEEP_TONE_CONTROLLER_ASSERT_SVH

`ifndef SYNTHESIS
`define PBTC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define PBTC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define PBTC_ASSERT_SAME(lbl, ante, cons, msg)
`define PBTC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ hw/rtl/pbtc_pkg.sv @@
// Shared types, constants and zone decoding for the proximity beep tone controller.
// No dependencies.
`timescale 1ns / 1ps

package pbtc_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned NOW_W         = 32;
  localparam int unsigned DIST_W        = 10;
  localparam int unsigned RATE_W        = 20;
  localparam int unsigned PITCH_W       = 12;
  localparam int unsigned LEN_W         = 9;
  localparam int unsigned RELOAD_W      = 16;
  localparam int unsigned CMP_W         = 15;
  localparam int unsigned DIV_CNT_W     = 5;

  localparam logic [RATE_W-1:0]    RATE_RESET   = 20'd100000;
  localparam logic [RELOAD_W-1:0]  RELOAD_RESET = 16'd99;
  localparam logic [RELOAD_W-1:0]  RELOAD_MIN   = 16'd10;
  localparam logic [RELOAD_W-1:0]  RELOAD_MAX   = 16'd65535;
  localparam logic [DIV_CNT_W-1:0] DIV_STEPS    = 5'(RATE_W);

  localparam logic [DIST_W-1:0]  DIST_FAR_MIN = 10'd11;
  localparam logic [DIST_W-1:0]  DIST_NEAR_MAX = 10'd5;
  localparam logic [DIST_W-1:0]  DIST_MID_MAX  = 10'd8;

  localparam logic [PITCH_W-1:0] PITCH_NEAR = 12'd3500;
  localparam logic [PITCH_W-1:0] PITCH_STEP = 12'd250;
  localparam logic [LEN_W-1:0]   BEEP_NEAR  = 9'd180;
  localparam logic [LEN_W-1:0]   BEEP_STEP  = 9'd20;
  localparam logic [LEN_W-1:0]   GAP_NEAR   = 9'd80;
  localparam logic [LEN_W-1:0]   GAP_STEP   = 9'd30;
  localparam logic [PITCH_W-1:0] PITCH_MID  = 12'd2000;
  localparam logic [LEN_W-1:0]   BEEP_MID   = 9'd100;
  localparam logic [LEN_W-1:0]   GAP_MID    = 9'd350;
  localparam logic [PITCH_W-1:0] PITCH_OUT  = 12'd1500;
  localparam logic [LEN_W-1:0]   BEEP_OUT   = 9'd80;
  localparam logic [LEN_W-1:0]   GAP_OUT    = 9'd500;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_DIV,
    ST_OUT
  } pbtc_state_e;

  typedef struct packed {
    logic load;
    logic commit;
    logic div_start;
    logic div_step;
    logic div_finish;
  } pbtc_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
  } pbtc_status_t;

  typedef struct packed {
    logic [PITCH_W-1:0] pitch;
    logic [LEN_W-1:0]   beep;
    logic [LEN_W-1:0]   gap;
  } pbtc_zone_t;

  // Zone table for a distance already known to be 10 cm or less.
  function automatic pbtc_zone_t zone_lookup(input logic [DIST_W-1:0] dist_cm);
    pbtc_zone_t z;
    logic [2:0] step;
    step = 3'd0;
    if (dist_cm > 10'd1) begin
      step = 3'(dist_cm - 10'd1);
    end
    if (dist_cm <= DIST_NEAR_MAX) begin
      z.pitch = PITCH_NEAR - 12'(12'(step) * PITCH_STEP);
      z.beep  = BEEP_NEAR - 9'(9'(step) * BEEP_STEP);
      z.gap   = GAP_NEAR + 9'(9'(step) * GAP_STEP);
    end else if (dist_cm <= DIST_MID_MAX) begin
      z.pitch = PITCH_MID;
      z.beep  = BEEP_MID;
      z.gap   = GAP_MID;
    end else begin
      z.pitch = PITCH_OUT;
      z.beep  = BEEP_OUT;
      z.gap   = GAP_OUT;
    end
    return z;
  endfunction

endpackage

@@ hw/rtl/pbtc_ctrl.sv @@
// Sequencing state machine for the proximity beep tone controller.
// Depends on pbtc_pkg; drives commands into pbtc_datapath.
`timescale 1ns / 1ps

module pbtc_ctrl import pbtc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  input  pbtc_status_t status_i,
  output pbtc_cmd_t    cmd_o
);

  pbtc_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        state_d = status_i.need_div ? ST_DIV : ST_OUT;
      end
      ST_DIV: begin
        if (status_i.div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o       = 1'b0;
    out_valid_o      = 1'b0;
    cmd_o            = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_EVAL: begin
        cmd_o.commit    = 1'b1;
        cmd_o.div_start = status_i.need_div;
      end
      ST_DIV: begin
        cmd_o.div_step   = !status_i.div_done;
        cmd_o.div_finish = status_i.div_done;
      end
      ST_OUT: begin
        out_valid_o = 1'b1;
      end
      default: ;
    endcase
  end

endmodule

@@ hw/rtl/pbtc_datapath.sv @@
// Datapath: beep state, zone decode, phase timing and the serial reload divider.
// Depends on pbtc_pkg; commanded by pbtc_ctrl.
`timescale 1ns / 1ps

module pbtc_datapath import pbtc_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbtc_cmd_t           cmd_i,
  output pbtc_status_t        status_o,
  input  logic                cfg_we_i,
  input  logic [RATE_W-1:0]   cfg_wdata_i,
  input  logic [DIST_W-1:0]   distance_i,
  input  logic [NOW_W-1:0]    now_ms_i,
  output logic                tone_on_o,
  output logic [RELOAD_W-1:0] reload_value_o,
  output logic [CMP_W-1:0]    compare_value_o,
  output logic                reconfigured_o
);

  logic [RATE_W-1:0]    rate_q;
  logic [DIST_W-1:0]    dist_q;
  logic [TIME_BITS-1:0] now_q;
  logic [TIME_BITS-1:0] last_q;
  logic                 phase_q;
  logic                 tone_q;
  logic [RELOAD_W-1:0]  reload_q;
  logic                 recfg_q;

  logic [PITCH_W-1:0]   rem_q;
  logic [RATE_W-1:0]    quo_q;
  logic [DIV_CNT_W-1:0] cnt_q;

  // Zero-extend or truncate the millisecond time to the internal time width.
  logic [TIME_BITS+NOW_W-1:0] now_wide;
  logic [TIME_BITS+LEN_W-1:0] len_wide;
  logic [TIME_BITS-1:0]       now_in;
  logic [TIME_BITS-1:0]       elapsed;
  logic [TIME_BITS-1:0]       len_ext;
  logic [LEN_W-1:0]           len;
  logic                       far;
  logic                       toggle;
  pbtc_zone_t                 zone;

  assign now_wide = {{TIME_BITS{1'b0}}, now_ms_i};
  assign now_in   = now_wide[TIME_BITS-1:0];

  assign far     = (dist_q >= DIST_FAR_MIN);
  assign zone    = zone_lookup(dist_q);
  assign len     = phase_q ? zone.beep : zone.gap;
  assign len_wide = {{TIME_BITS{1'b0}}, len};
  assign len_ext = len_wide[TIME_BITS-1:0];
  assign elapsed = now_q - last_q;
  assign toggle  = !far && (elapsed >= len_ext);

  assign status_o.need_div = toggle && !phase_q;
  assign status_o.div_done = (cnt_q == DIV_STEPS);

  // One restoring division step per cycle: rate / pitch.
  logic [PITCH_W:0]   trial;
  logic [PITCH_W:0]   diff;
  logic               q_bit;
  logic [PITCH_W-1:0] rem_next;

  assign trial    = {rem_q, quo_q[RATE_W-1]};
  assign diff     = trial - {1'b0, zone.pitch};
  assign q_bit    = (trial >= {1'b0, zone.pitch});
  assign rem_next = q_bit ? diff[PITCH_W-1:0] : trial[PITCH_W-1:0];

  // The quotient minus one saturates into the legal reload range.
  logic [RELOAD_W-1:0] reload_sat;
  always_comb begin
    if (quo_q < RATE_W'(RELOAD_MIN) + RATE_W'(1)) begin
      reload_sat = RELOAD_MIN;
    end else if (quo_q > RATE_W'(RELOAD_MAX) + RATE_W'(1)) begin
      reload_sat = RELOAD_MAX;
    end else begin
      reload_sat = RELOAD_W'(quo_q - RATE_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= RATE_RESET;
    end else if (cfg_we_i) begin
      rate_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dist_q <= distance_i;
      now_q  <= now_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q   <= '0;
      phase_q  <= 1'b0;
      tone_q   <= 1'b0;
      reload_q <= RELOAD_RESET;
      recfg_q  <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        if (far) begin
          recfg_q <= tone_q;
          tone_q  <= 1'b0;
        end else if (toggle) begin
          last_q  <= now_q;
          phase_q <= !phase_q;
          recfg_q <= 1'b1;
          tone_q  <= !phase_q;
        end else begin
          recfg_q <= 1'b0;
        end
      end
      if (cmd_i.div_finish) begin
        reload_q <= reload_sat;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.div_start) begin
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      cnt_q <= cnt_q + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= rate_q;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[RATE_W-2:0], q_bit};
    end
  end

  assign tone_on_o       = tone_q;
  assign reload_value_o  = reload_q;
  assign compare_value_o = reload_q[RELOAD_W-1:1];
  assign reconfigured_o  = recfg_q;

endmodule

@@ hw/rtl/proximity_beep_tone_controller.sv @@
// Proximity beep tone controller, top level. One word in, one word out.
// A word is loaded, evaluated in ST_EVAL and then offered as a result word in ST_OUT;
// a word that starts a tone phase first passes through ST_DIV, where the 20-step serial
// divider computes the reload. A new word is taken only after the last result is taken.
// Reset (rst_ni, async, active low): gap phase, muted, reload 99, counter rate 100000 Hz.
`timescale 1ns / 1ps

module proximity_beep_tone_controller import pbtc_pkg::*; #(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [RATE_W-1:0]   cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [DIST_W-1:0]   distance_i,
  input  logic [NOW_W-1:0]    now_ms_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                tone_on_o,
  output logic [RELOAD_W-1:0] reload_value_o,
  output logic [CMP_W-1:0]    compare_value_o,
  output logic                reconfigured_o
);

  `include "proximity_beep_tone_controller_assert.svh"

  pbtc_cmd_t    cmd;
  pbtc_status_t status;

  pbtc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pbtc_datapath #(
    .TIME_BITS (TIME_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .distance_i      (distance_i),
    .now_ms_i        (now_ms_i),
    .tone_on_o       (tone_on_o),
    .reload_value_o  (reload_value_o),
    .compare_value_o (compare_value_o),
    .reconfigured_o  (reconfigured_o)
  );

  // A word is taken only while no result is pending.
  `PBTC_ASSERT_SAME(a_no_overlap, in_ready_o, !out_valid_o, "input ready while result pending")
  // The result never shows in the cycle right after an accept.
  `PBTC_ASSERT_NEXT(a_eval_gap, in_valid_i && in_ready_o, !out_valid_o, "result too early")
  // A sounding tone always carries a reload in the legal range.
  `PBTC_ASSERT_SAME(a_reload_range, out_valid_o && tone_on_o, reload_value_o >= RELOAD_MIN, "reload below minimum")

endmodule

@@ tb/testbench.sv @@
// Self-checking bench for proximity_beep_tone_controller: a directed table, then random words
// under several counter rates, with random idling and a long receiver hold-off.
// Depends on pbtc_pkg and the RTL of the block; reads no files.
`timescale 1ns / 1ps

module testbench;
  import pbtc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned DRAIN_CYCLES   = 30;
  localparam int unsigned RANDOM_WORDS   = 92;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned NUM_RATES      = 6;
  localparam int unsigned NUM_ROWS       = 19;

  typedef struct packed {
    logic                tone_on;
    logic [RELOAD_W-1:0] reload;
    logic [CMP_W-1:0]    compare;
    logic                reconfigured;
  } tone_word_t;

  typedef struct packed {
    logic [DIST_W-1:0] dist_cm;
    logic [NOW_W-1:0]  now;
    bit                typed;
    tone_word_t        want;
  } beep_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [RATE_W-1:0]   cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [DIST_W-1:0]   distance_i;
  logic [NOW_W-1:0]    now_ms_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic                tone_on_o;
  logic [RELOAD_W-1:0] reload_value_o;
  logic [CMP_W-1:0]    compare_value_o;
  logic                reconfigured_o;

  // Predicted state of the beeper.
  logic [RATE_W-1:0]   rate_hz;
  logic                ph_tone;
  logic [NOW_W-1:0]    ph_start_ms;
  logic                buzz_on;
  logic [RELOAD_W-1:0] held_reload;

  tone_word_t          tone_settings_due[$];
  int unsigned         fail_count;
  logic [NOW_W-1:0]    clock_ms;
  bit                  hold_req;

  logic [RATE_W-1:0] rate_plan [NUM_RATES] = '{
    20'd1000000, 20'd1000, 20'd0, 20'hFFFFF, 20'd250000, RATE_RESET
  };

  // Rows with a typed result are read straight off the reset state.
  beep_row_t dir_rows [NUM_ROWS] = '{
    '{10'd1023, 32'd0,          1'b1, '{1'b0, 16'd99, 15'd49, 1'b0}},
    '{10'd0,    32'd5,          1'b1, '{1'b0, 16'd99, 15'd49, 1'b0}},
    '{10'd0,    32'd80,         1'b0, '0},
    '{10'd1,    32'd200,        1'b0, '0},
    '{10'd11,   32'd210,        1'b0, '0},
    '{10'd11,   32'd220,        1'b0, '0},
    '{10'd5,    32'd260,        1'b0, '0},
    '{10'd5,    32'd460,        1'b0, '0},
    '{10'd6,    32'd560,        1'b0, '0},
    '{10'd8,    32'd909,        1'b0, '0},
    '{10'd8,    32'd910,        1'b0, '0},
    '{10'd9,    32'd990,        1'b0, '0},
    '{10'd10,   32'd1490,       1'b0, '0},
    '{10'd3,    32'hFFFF_FF00,  1'b0, '0},
    '{10'd3,    32'h0000_0050,  1'b0, '0},
    '{10'd2,    32'h0000_00EF,  1'b0, '0},
    '{10'd4,    32'h0000_00C8,  1'b0, '0},
    '{10'd512,  32'hAAAA_AAAA,  1'b0, '0},
    '{10'd7,    32'h5555_5555,  1'b0, '0}
  };

  proximity_beep_tone_controller i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .distance_i      (distance_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .tone_on_o       (tone_on_o),
    .reload_value_o  (reload_value_o),
    .compare_value_o (compare_value_o),
    .reconfigured_o  (reconfigured_o)
  );

  always #5 clk_i = ~clk_i;

  // Pitch, beep length and gap length for a distance of 1 to 10 cm.
  function automatic void zone_of(input logic [DIST_W-1:0] d, output int unsigned pitch,
                                  output int unsigned beep, output int unsigned gap);
    if (d <= 5) begin
      pitch = 3500 - (d - 1) * 250;
      beep  = 180 - (d - 1) * 20;
      gap   = 80 + (d - 1) * 30;
    end else if (d <= 8) begin
      pitch = 2000;
      beep  = 100;
      gap   = 350;
    end else begin
      pitch = 1500;
      beep  = 80;
      gap   = 500;
    end
  endfunction

  function automatic logic [RELOAD_W-1:0] reload_from_pitch(input int unsigned pitch);
    int unsigned q;
    q = int'(rate_hz) / pitch;
    if (q < 11) begin
      return RELOAD_MIN;
    end
    if (q - 1 > 65535) begin
      return RELOAD_MAX;
    end
    return RELOAD_W'(q - 1);
  endfunction

  // Advances the predicted beeper by one input word and returns the setting it reports.
  function automatic tone_word_t next_tone_setting(input logic [DIST_W-1:0] dist_cm,
                                                   input logic [NOW_W-1:0] now);
    tone_word_t        w;
    logic [DIST_W-1:0] d;
    logic [NOW_W-1:0]  elapsed;
    int unsigned       pitch, beep, gap, span;
    logic              recfg;
    recfg = 1'b0;
    if (dist_cm > 10) begin
      recfg   = buzz_on;
      buzz_on = 1'b0;
    end else begin
      d = (dist_cm == 0) ? DIST_W'(1) : dist_cm;
      zone_of(d, pitch, beep, gap);
      span    = ph_tone ? beep : gap;
      elapsed = now - ph_start_ms;
      if (elapsed >= span) begin
        ph_start_ms = now;
        ph_tone     = ~ph_tone;
        recfg       = 1'b1;
        if (ph_tone) begin
          held_reload = reload_from_pitch(pitch);
          buzz_on     = 1'b1;
        end else begin
          buzz_on = 1'b0;
        end
      end
    end
    w.tone_on      = buzz_on;
    w.reload       = held_reload;
    w.compare      = held_reload[RELOAD_W-1:1];
    w.reconfigured = recfg;
    return w;
  endfunction

  // Offers one word and keeps it steady until it is taken; valid stays high afterwards.
  task automatic send_word(input logic [DIST_W-1:0] d, input logic [NOW_W-1:0] now,
                           input bit typed, input tone_word_t want);
    tone_word_t w;
    in_valid_i <= 1'b1;
    distance_i <= d;
    now_ms_i   <= now;
    do @(posedge clk_i); while (!in_ready_o);
    w = next_tone_setting(d, now);
    tone_settings_due.push_back(typed ? want : w);
  endtask

  task automatic sender_gap();
    int unsigned r, g;
    r = $urandom_range(0, 99);
    if (r < 50) begin
      g = 0;
    end else if (r < 92) begin
      g = $urandom_range(1, 3);
    end else begin
      g = $urandom_range(10, 40);
    end
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] v);
    in_valid_i <= 1'b0;
    while (tone_settings_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    rate_hz  = v;
  endtask

  // Mostly a steadily advancing clock with near distances, so that phases keep toggling;
  // some words land on or just before a phase boundary, and a few jump the clock anywhere.
  task automatic random_word(output logic [DIST_W-1:0] d, output logic [NOW_W-1:0] now);
    int unsigned       r, pitch, beep, gap;
    logic [DIST_W-1:0] zd;
    r = $urandom_range(0, 99);
    if (r < 72) begin
      d = DIST_W'($urandom_range(0, 10));
    end else if (r < 88) begin
      d = DIST_W'($urandom_range(11, 40));
    end else begin
      d = DIST_W'($urandom_range(0, 1023));
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      clock_ms = $urandom();
    end else if (r < 20) begin
      zd = (d == 0) ? DIST_W'(1) : ((d > 10) ? DIST_W'(10) : d);
      zone_of(zd, pitch, beep, gap);
      clock_ms = ph_start_ms + (ph_tone ? beep : gap) - $urandom_range(0, 1);
    end else begin
      clock_ms = clock_ms + $urandom_range(0, 260);
    end
    now = clock_ms;
  endtask

  // Receiver: ready stretches, short and long stalls, and one long hold-off on request.
  initial begin
    int unsigned r;
    wait (rst_ni === 1'b1);
    forever begin
      r = $urandom_range(0, 99);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
      end else if (r < 45) begin
        out_ready_i <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end else if (r < 92) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(20, 60)) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    tone_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (tone_settings_due.size() == 0) begin
        $error("result word with no expectation pending");
        fail_count++;
      end else begin
        want = tone_settings_due.pop_front();
        if (tone_on_o !== want.tone_on) begin
          $error("tone_on: expected %0d, got %0d", want.tone_on, tone_on_o);
          fail_count++;
        end
        if (reload_value_o !== want.reload) begin
          $error("reload_value: expected %0d, got %0d", want.reload, reload_value_o);
          fail_count++;
        end
        if (compare_value_o !== want.compare) begin
          $error("compare_value: expected %0d, got %0d", want.compare, compare_value_o);
          fail_count++;
        end
        if (reconfigured_o !== want.reconfigured) begin
          $error("reconfigured: expected %0d, got %0d", want.reconfigured, reconfigured_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: ends the run when neither channel has moved a word for too long.
  initial begin
    int unsigned quiet;
    quiet = 0;
    wait (rst_ni === 1'b1);
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    logic [DIST_W-1:0] d;
    logic [NOW_W-1:0]  now;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    distance_i  = '0;
    now_ms_i    = '0;
    out_ready_i = 1'b0;
    fail_count  = 0;
    hold_req    = 1'b0;
    rate_hz     = RATE_RESET;
    ph_tone     = 1'b0;
    ph_start_ms = '0;
    buzz_on     = 1'b0;
    held_reload = RELOAD_RESET;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NUM_ROWS; i++) begin
      send_word(dir_rows[i].dist_cm, dir_rows[i].now, dir_rows[i].typed, dir_rows[i].want);
      sender_gap();
    end
    clock_ms = ph_start_ms;

    for (int p = 0; p < NUM_RATES; p++) begin
      write_rate(rate_plan[p]);
      for (int n = 0; n < RANDOM_WORDS; n++) begin
        // Partway into the second rate, hold the receiver off while words keep coming.
        if (p == 1 && n == 30) begin
          hold_req = 1'b1;
        end
        random_word(d, now);
        send_word(d, now, 1'b0, '0);
        sender_gap();
      end
    end

    in_valid_i <= 1'b0;
    while (tone_settings_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/pbtc_pkg.sv
hw/rtl/pbtc_ctrl.sv
hw/rtl/pbtc_datapath.sv
hw/rtl/proximity_beep_tone_controller.sv
tb/testbench.sv
